// ===== design/clsu_pkg.sv =====
// ----------------------------------------------------------------------------
// clsu_pkg
// Shared types and codes for the coprocessor link supervisor: event and
// action codes, link phase codes, register map and configuration bundle.
// ----------------------------------------------------------------------------
package clsu_pkg;

    // register port address width: three 32-bit registers at 4*i
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_GRACE   = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_MAXBAD  = 2'd2;

    // register reset values
    localparam logic [7:0] GRACE_RST   = 8'd2;
    localparam logic [7:0] TIMEOUT_RST = 8'd20;
    localparam logic [3:0] MAXBAD_RST  = 4'd3;

    // input event codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_DONE  = 2'd1;
    localparam logic [1:0] CMD_ERROR = 2'd2;
    localparam logic [1:0] CMD_BYTE  = 2'd3;

    // action codes
    localparam logic [1:0] ACT_NONE      = 2'd0;
    localparam logic [1:0] ACT_HANDSHAKE = 2'd1;
    localparam logic [1:0] ACT_SEND      = 2'd2;
    localparam logic [1:0] ACT_READ      = 2'd3;

    // link phase codes
    localparam logic [2:0] PH_START     = 3'd0;
    localparam logic [2:0] PH_HS_BUSY   = 3'd1;
    localparam logic [2:0] PH_WAIT_SEND = 3'd2;
    localparam logic [2:0] PH_SEND_BUSY = 3'd3;
    localparam logic [2:0] PH_WAIT_READ = 3'd4;
    localparam logic [2:0] PH_READ_BUSY = 3'd5;

    localparam logic [7:0] FRAME_SUM_OK = 8'hFF;
    localparam logic [7:0] COUNT_MAX    = 8'hFF;
    localparam logic [3:0] BAD_MAX      = 4'hF;

    // configuration bundle handed from the register block
    typedef struct packed {
        logic [7:0] grace_ticks;
        logic [7:0] transfer_timeout_ticks;
        logic [3:0] max_bad_frames;
    } cfg_t;

endpackage

// ===== design/clsu_if.sv =====
// ----------------------------------------------------------------------------
// clsu channel interfaces
// Valid/ready channels for link events and for supervisor results.
// ----------------------------------------------------------------------------
interface clsu_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface clsu_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic       frame_good;
    logic       frame_bad;
    logic [3:0] bad_frame_count;

    modport source (output valid, output action, output frame_good,
                    output frame_bad, output bad_frame_count, input ready);
    modport sink (input valid, input action, input frame_good,
                  input frame_bad, input bad_frame_count, output ready);
endinterface

// ===== design/clsu_apb_regs.sv =====
// ----------------------------------------------------------------------------
// clsu_apb_regs
// Configuration registers of the link supervisor behind an APB-style port.
// ----------------------------------------------------------------------------
module clsu_apb_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [clsu_pkg::ADDR_W-1:0] paddr,
    input  logic [clsu_pkg::DATA_W-1:0] pwdata,
    output logic [clsu_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output clsu_pkg::cfg_t             cfg
);

    logic [7:0] grace_reg;
    logic [7:0] timeout_reg;
    logic [3:0] maxbad_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grace_reg   <= clsu_pkg::GRACE_RST;
            timeout_reg <= clsu_pkg::TIMEOUT_RST;
            maxbad_reg  <= clsu_pkg::MAXBAD_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                clsu_pkg::REG_GRACE:   grace_reg   <= pwdata[7:0];
                clsu_pkg::REG_TIMEOUT: timeout_reg <= pwdata[7:0];
                clsu_pkg::REG_MAXBAD:  maxbad_reg  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            clsu_pkg::REG_GRACE:   prdata = {24'd0, grace_reg};
            clsu_pkg::REG_TIMEOUT: prdata = {24'd0, timeout_reg};
            clsu_pkg::REG_MAXBAD:  prdata = {28'd0, maxbad_reg};
            default:               prdata = '0;
        endcase
    end

    assign cfg.grace_ticks            = grace_reg;
    assign cfg.transfer_timeout_ticks = timeout_reg;
    assign cfg.max_bad_frames         = maxbad_reg;

endmodule

// ===== design/coprocessor_link_supervisor_unit.sv =====
// An accepted event is captured in the event register, then its result in the
// result register; the link state updates when the result is registered.
// Throughput: one event per cycle while the result output is not stalled; the state
// step is a single pass of counters and compares, so back-to-back events run at full rate.
// Reset (rst_n low, asynchronous): link in start phase, all counters zero,
// registers at their defaults, no result pending.
// ----------------------------------------------------------------------------
// coprocessor_link_supervisor_unit
// Supervises a polled bus link: grace timer, transfer timeout, frame checksum
// and consecutive bad frame limit, issuing one action per event.
// ----------------------------------------------------------------------------
module coprocessor_link_supervisor_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    clsu_in_if.sink                     in_ch,
    clsu_out_if.source                  out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [clsu_pkg::ADDR_W-1:0] paddr,
    input  logic [clsu_pkg::DATA_W-1:0] pwdata,
    output logic [clsu_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    clsu_pkg::cfg_t cfg;

    // event stage
    logic       stage_valid_reg;
    logic [1:0] cmd_reg;
    logic [7:0] byte_reg;

    // link state
    logic [2:0] phase_reg,   phase_next;
    logic [7:0] grace_reg,   grace_next;
    logic [7:0] timeout_reg, timeout_next;
    logic [3:0] bad_reg,     bad_next;
    logic [7:0] sum_reg,     sum_next;

    // result stage
    logic       out_valid_reg;
    logic [1:0] action_reg,  action_next;
    logic       good_reg,    good_next;
    logic       badf_reg,    badf_next;
    logic [3:0] count_reg;

    logic       advance;
    logic       fire;
    logic       in_xfer;
    logic       do_start;
    logic       do_wait;
    logic [2:0] wait_phase;
    logic [7:0] tick_to;

    clsu_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake: result register frees the event stage
    assign advance     = !out_valid_reg || out_ch.ready;
    assign fire        = stage_valid_reg && advance;
    assign in_ch.ready = !stage_valid_reg || advance;
    assign in_xfer     = in_ch.valid && in_ch.ready;

    // one supervisor step on the registered event
    always_comb
    begin
        phase_next   = phase_reg;
        grace_next   = grace_reg;
        timeout_next = timeout_reg;
        bad_next     = bad_reg;
        sum_next     = sum_reg;
        action_next  = clsu_pkg::ACT_NONE;
        good_next    = 1'b0;
        badf_next    = 1'b0;
        do_start     = 1'b0;
        do_wait      = 1'b0;
        wait_phase   = clsu_pkg::PH_WAIT_SEND;
        tick_to      = (timeout_reg != clsu_pkg::COUNT_MAX) ? timeout_reg + 8'd1
                                                            : timeout_reg;

        // grace timer counts every tick, saturating at COUNT_MAX
        if (cmd_reg == clsu_pkg::CMD_TICK && grace_reg != clsu_pkg::COUNT_MAX)
            grace_next = grace_reg + 8'd1;

        unique case (phase_reg)
            clsu_pkg::PH_HS_BUSY,
            clsu_pkg::PH_SEND_BUSY,
            clsu_pkg::PH_READ_BUSY:
            begin
                case (cmd_reg)
                    clsu_pkg::CMD_TICK:
                    begin
                        timeout_next = tick_to;
                        if (tick_to >= cfg.transfer_timeout_ticks)
                            do_start = 1'b1;
                    end
                    clsu_pkg::CMD_ERROR:
                        do_start = 1'b1;
                    clsu_pkg::CMD_BYTE:
                    begin
                        if (phase_reg == clsu_pkg::PH_READ_BUSY)
                            sum_next = sum_reg + byte_reg;
                    end
                    default:
                    begin
                        // transfer finished ok
                        if (phase_reg == clsu_pkg::PH_HS_BUSY)
                        begin
                            grace_next = '0;
                            do_wait    = 1'b1;
                        end
                        else if (phase_reg == clsu_pkg::PH_SEND_BUSY)
                        begin
                            phase_next = clsu_pkg::PH_WAIT_READ;
                            wait_phase = clsu_pkg::PH_WAIT_READ;
                            // no bad frame check on this path
                            if (grace_next >= cfg.grace_ticks)
                            begin
                                grace_next   = grace_next - cfg.grace_ticks;
                                timeout_next = '0;
                                phase_next   = clsu_pkg::PH_READ_BUSY;
                                sum_next     = '0;
                                action_next  = clsu_pkg::ACT_READ;
                            end
                        end
                        else
                        begin
                            // status frame complete: check its byte sum
                            if (sum_reg == clsu_pkg::FRAME_SUM_OK)
                            begin
                                good_next = 1'b1;
                                bad_next  = '0;
                            end
                            else
                            begin
                                badf_next = 1'b1;
                                if (bad_reg != clsu_pkg::BAD_MAX)
                                    bad_next = bad_reg + 4'd1;
                            end
                            do_wait = 1'b1;
                        end
                    end
                endcase
            end
            clsu_pkg::PH_WAIT_SEND,
            clsu_pkg::PH_WAIT_READ:
            begin
                if (cmd_reg == clsu_pkg::CMD_TICK)
                begin
                    wait_phase = phase_reg;
                    if (grace_next >= cfg.grace_ticks)
                    begin
                        grace_next   = grace_next - cfg.grace_ticks;
                        timeout_next = '0;
                        if (phase_reg == clsu_pkg::PH_WAIT_SEND)
                        begin
                            phase_next  = clsu_pkg::PH_SEND_BUSY;
                            action_next = clsu_pkg::ACT_SEND;
                        end
                        else
                        begin
                            phase_next  = clsu_pkg::PH_READ_BUSY;
                            sum_next    = '0;
                            action_next = clsu_pkg::ACT_READ;
                        end
                    end
                end
            end
            default:
                do_start = 1'b1;
        endcase

        // after a handshake or a read: restart at the bad frame limit, else enter the send wait or start a send at once
        if (do_wait)
        begin
            if (bad_next >= cfg.max_bad_frames)
                do_start = 1'b1;
            else
            begin
                phase_next = wait_phase;
                if (grace_next >= cfg.grace_ticks)
                begin
                    grace_next   = grace_next - cfg.grace_ticks;
                    timeout_next = '0;
                    phase_next   = clsu_pkg::PH_SEND_BUSY;
                    action_next  = clsu_pkg::ACT_SEND;
                end
            end
        end

        // link restart: bus reset and handshake
        if (do_start)
        begin
            bad_next     = '0;
            timeout_next = '0;
            phase_next   = clsu_pkg::PH_HS_BUSY;
            action_next  = clsu_pkg::ACT_HANDSHAKE;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            phase_reg       <= clsu_pkg::PH_START;
            grace_reg       <= '0;
            timeout_reg     <= '0;
            bad_reg         <= '0;
            sum_reg         <= '0;
        end
        else
        begin
            if (in_xfer)
                stage_valid_reg <= 1'b1;
            else if (advance)
                stage_valid_reg <= 1'b0;

            if (fire)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                grace_reg     <= grace_next;
                timeout_reg   <= timeout_next;
                bad_reg       <= bad_next;
                sum_reg       <= sum_next;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg  <= in_ch.cmd;
            byte_reg <= in_ch.rx_byte;
        end
        if (fire)
        begin
            action_reg <= action_next;
            good_reg   <= good_next;
            badf_reg   <= badf_next;
            count_reg  <= bad_next;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.action          = action_reg;
    assign out_ch.frame_good      = good_reg;
    assign out_ch.frame_bad       = badf_reg;
    assign out_ch.bad_frame_count = count_reg;

`ifndef NO_ASSERTIONS
    // a restart always shows a cleared bad frame count
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && action_reg == clsu_pkg::ACT_HANDSHAKE) |-> (count_reg == 4'd0))
        else $error("restart result with nonzero bad frame count");

    // a finished frame never starts a status read in the same step
    a_frame_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (good_reg || badf_reg)) |->
        (action_reg != clsu_pkg::ACT_READ && !(good_reg && badf_reg)))
        else $error("frame verdict with read action or both verdicts");

    // events are refused only while a result is stalled behind a full stage
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> (stage_valid_reg && out_valid_reg && !out_ch.ready))
        else $error("event input stalled without a stalled result");

    // a good frame clears the count
    a_good_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && good_reg) |-> (count_reg == 4'd0))
        else $error("good frame with nonzero bad frame count");

    // each processed event yields a result at the next edge
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed event produced no result");
`endif

endmodule
